@@ design/rlbd_pkg.sv @@
// ----------------------------------------------------------------------------
// Run-length byte decoder package
// Shared widths, reset values, command bytes and register indexes.
// ----------------------------------------------------------------------------
package rlbd_pkg;

  localparam int unsigned OUT_DEPTH_DEF  = 8192;
  localparam int unsigned BYTE_W         = 8;
  localparam int unsigned OUT_LIMIT_W    = 14;
  localparam int unsigned HEADER_LEN_W   = 4;
  localparam int unsigned PADDR_W        = 3;
  localparam int unsigned PDATA_W        = 32;

  localparam logic [OUT_LIMIT_W-1:0]  OUT_LIMIT_RST  = 14'd7923;
  localparam logic [HEADER_LEN_W-1:0] HEADER_LEN_RST = 4'd8;

  localparam logic [BYTE_W-1:0] CMD_END     = 8'h00;
  localparam logic [BYTE_W-1:0] CMD_LITERAL = 8'hFF;

  localparam logic REG_OUT_LIMIT  = 1'b0;
  localparam logic REG_HEADER_LEN = 1'b1;

endpackage

@@ design/rlbd_if.sv @@
// ----------------------------------------------------------------------------
// Run-length byte decoder channels
// Valid/ready channels for compressed input bytes and buffer write words.
// ----------------------------------------------------------------------------
interface rlbd_in_if
  import rlbd_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  logic              last_byte;

  modport source (output valid, output in_byte, output last_byte, input ready);
  modport sink   (input valid, input in_byte, input last_byte, output ready);
endinterface

interface rlbd_out_if
  import rlbd_pkg::*;
  #(
    parameter int unsigned ADDR_W = $clog2(OUT_DEPTH_DEF)
  ) ();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] write_addr;
  logic [BYTE_W-1:0] write_value;
  logic [BYTE_W-1:0] run_length;
  logic              end_seen;
  logic              overrun;

  modport source (output valid, output write_addr, output write_value,
                  output run_length, output end_seen, output overrun, input ready);
  modport sink   (input valid, input write_addr, input write_value,
                  input run_length, input end_seen, input overrun, output ready);
endinterface

@@ design/run_length_byte_decoder_unit.sv @@
// ----------------------------------------------------------------------------
// Run-length byte decoder unit
// Turns compressed bytes into output buffer write words, one word per byte.
// ----------------------------------------------------------------------------
// The word for a byte is registered and appears in the cycle after the byte is taken.
// Throughput: one byte per cycle, set by the single decode step that runs
// between the decode state registers and the result register; the input
// stalls only while a finished word waits to be taken.
// Reset clears the decode state and loads the register reset values.
module run_length_byte_decoder_unit
  import rlbd_pkg::*;
  (
    input  logic                clk_i,
    input  logic                rst_ni,
    rlbd_in_if.sink             in_i,
    rlbd_out_if.source          out_o,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready
  );

  localparam int unsigned ADDR_W = $clog2(OUT_DEPTH_DEF);
  localparam int unsigned POS_W  = $clog2(OUT_DEPTH_DEF + 1);
  localparam int unsigned LIM_W  = (POS_W > OUT_LIMIT_W) ? POS_W : OUT_LIMIT_W;
  localparam int unsigned CMP_W  = LIM_W + 1;

  localparam logic [2:0] MODE_HEADER  = 3'd0;
  localparam logic [2:0] MODE_CMD     = 3'd1;
  localparam logic [2:0] MODE_COUNT   = 3'd2;
  localparam logic [2:0] MODE_LITERAL = 3'd3;
  localparam logic [2:0] MODE_REPEAT  = 3'd4;
  localparam logic [2:0] MODE_END     = 3'd5;
  localparam logic [2:0] MODE_HALT    = 3'd6;

  logic [OUT_LIMIT_W-1:0]  out_limit_q;
  logic [HEADER_LEN_W-1:0] header_len_q;

  logic [2:0]              mode_q, mode_d;
  logic [BYTE_W-1:0]       pend_q, pend_d;
  logic [POS_W-1:0]        pos_q, pos_d;
  logic [HEADER_LEN_W-1:0] hleft_q, hleft_d;
  logic                    ovr_q, ovr_d;
  logic                    end_q, end_d;
  logic                    start_q;

  logic                    out_valid_q;
  logic [ADDR_W-1:0]       addr_q, addr_d;
  logic [BYTE_W-1:0]       val_q, val_d;
  logic [BYTE_W-1:0]       len_q, len_d;
  logic                    end_out_q, ovr_out_q;

  logic                    accept;
  logic                    cfg_wr;
  logic [LIM_W-1:0]        lim_ext;
  logic [LIM_W-1:0]        eff_lim;
  logic                    fits_one, fits_byte, fits_pend;
  logic [2:0]              mode_cur;
  logic [HEADER_LEN_W-1:0] hleft_cur;
  logic [BYTE_W-1:0]       c;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    prdata = '0;
    case (paddr[2])
      REG_OUT_LIMIT:  prdata = PDATA_W'(out_limit_q);
      REG_HEADER_LEN: prdata = PDATA_W'(header_len_q);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_limit_q  <= OUT_LIMIT_RST;
      header_len_q <= HEADER_LEN_RST;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_OUT_LIMIT:  out_limit_q  <= pwdata[OUT_LIMIT_W-1:0];
        REG_HEADER_LEN: header_len_q <= pwdata[HEADER_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;
  assign c          = in_i.in_byte;

  assign lim_ext   = LIM_W'(out_limit_q);
  assign eff_lim   = (lim_ext > LIM_W'(OUT_DEPTH_DEF)) ? LIM_W'(OUT_DEPTH_DEF) : lim_ext;
  assign fits_one  = (CMP_W'(pos_q) + CMP_W'(1)) <= CMP_W'(eff_lim);
  assign fits_byte = (CMP_W'(pos_q) + CMP_W'(c)) <= CMP_W'(eff_lim);
  assign fits_pend = (CMP_W'(pos_q) + CMP_W'(pend_q)) <= CMP_W'(eff_lim);

  always_comb begin
    hleft_cur = start_q ? header_len_q : hleft_q;
    mode_cur  = start_q ? MODE_HEADER : mode_q;
    if (mode_cur == MODE_HEADER && hleft_cur == '0) begin
      mode_cur = MODE_CMD;
    end

    mode_d  = mode_cur;
    pend_d  = pend_q;
    pos_d   = pos_q;
    hleft_d = hleft_cur;
    ovr_d   = ovr_q;
    end_d   = end_q;
    addr_d  = '0;
    val_d   = '0;
    len_d   = '0;

    case (mode_cur)
      MODE_HEADER: begin
        if (!fits_one) begin
          ovr_d  = 1'b1;
          mode_d = MODE_HALT;
        end else begin
          addr_d  = ADDR_W'(pos_q);
          val_d   = c;
          len_d   = BYTE_W'(1);
          pos_d   = pos_q + POS_W'(1);
          hleft_d = hleft_cur - HEADER_LEN_W'(1);
          if (hleft_d == '0) begin
            mode_d = MODE_CMD;
          end
        end
      end
      MODE_CMD: begin
        if (c == CMD_END) begin
          mode_d = MODE_END;
          end_d  = 1'b1;
        end else if (c == CMD_LITERAL) begin
          mode_d = MODE_COUNT;
        end else begin
          pend_d = c;
          mode_d = MODE_REPEAT;
        end
      end
      MODE_COUNT: begin
        if (c == '0) begin
          mode_d = MODE_CMD;
        end else if (!fits_byte) begin
          ovr_d  = 1'b1;
          mode_d = MODE_HALT;
        end else begin
          pend_d = c;
          mode_d = MODE_LITERAL;
        end
      end
      MODE_LITERAL: begin
        if (!fits_one) begin
          ovr_d  = 1'b1;
          mode_d = MODE_HALT;
        end else begin
          addr_d = ADDR_W'(pos_q);
          val_d  = c;
          len_d  = BYTE_W'(1);
          pos_d  = pos_q + POS_W'(1);
          pend_d = pend_q - BYTE_W'(1);
          if (pend_d == '0) begin
            mode_d = MODE_CMD;
          end
        end
      end
      MODE_REPEAT: begin
        if (!fits_pend) begin
          ovr_d  = 1'b1;
          mode_d = MODE_HALT;
        end else begin
          addr_d = ADDR_W'(pos_q);
          val_d  = c;
          len_d  = pend_q;
          pos_d  = pos_q + POS_W'(pend_q);
          pend_d = '0;
          mode_d = MODE_CMD;
        end
      end
      MODE_END, MODE_HALT: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_HEADER;
      pend_q  <= '0;
      pos_q   <= '0;
      hleft_q <= HEADER_LEN_RST;
      ovr_q   <= 1'b0;
      end_q   <= 1'b0;
      start_q <= 1'b1;
    end else if (accept) begin
      if (in_i.last_byte) begin
        mode_q  <= MODE_HEADER;
        pend_q  <= '0;
        pos_q   <= '0;
        hleft_q <= hleft_d;
        ovr_q   <= 1'b0;
        end_q   <= 1'b0;
        start_q <= 1'b1;
      end else begin
        mode_q  <= mode_d;
        pend_q  <= pend_d;
        pos_q   <= pos_d;
        hleft_q <= hleft_d;
        ovr_q   <= ovr_d;
        end_q   <= end_d;
        start_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      addr_q    <= addr_d;
      val_q     <= val_d;
      len_q     <= len_d;
      end_out_q <= end_d;
      ovr_out_q <= ovr_d;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.write_addr  = addr_q;
  assign out_o.write_value = val_q;
  assign out_o.run_length  = len_q;
  assign out_o.end_seen    = end_out_q;
  assign out_o.overrun     = ovr_out_q;

endmodule

@@ tb/rlbd_word_checker.sv @@
// ----------------------------------------------------------------------------
// Run-length byte decoder word checker
// Watches the byte channel and the register port, predicts the buffer write
// word that each accepted byte must produce, and compares every word taken
// from the output channel with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module rlbd_word_checker
  import rlbd_pkg::*;
  (
    input  logic               clk_i,
    input  logic               rst_ni,
    rlbd_in_if                 in_mon,
    rlbd_out_if                out_mon,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic               pready,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output int                 err_cnt_o,
    output int                 pending_o
  );

  localparam int unsigned ADDR_W = $clog2(OUT_DEPTH_DEF);

  typedef enum logic [2:0] {
    MODE_HEADER, MODE_CMD, MODE_COUNT, MODE_LITERAL, MODE_REPEAT, MODE_END, MODE_HALT
  } mode_e;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] value;
    logic [BYTE_W-1:0] run;
    logic              end_seen;
    logic              overrun;
  } wr_word_t;

  logic [OUT_LIMIT_W-1:0]  lim;
  logic [HEADER_LEN_W-1:0] hdr_len;
  logic [HEADER_LEN_W-1:0] hdr_left;
  mode_e                   mode;
  logic [BYTE_W-1:0]       count_left;
  int unsigned             out_pos;
  logic                    ovr_flag;
  logic                    end_flag;
  logic                    fresh_block;
  wr_word_t                words_due[$];
  int                      errs = 0;
  int                      waiting = 0;

  assign err_cnt_o = errs;
  assign pending_o = waiting;

  function automatic bit room_for(int unsigned n);
    int unsigned cap;
    cap = (lim > OUT_DEPTH_DEF) ? OUT_DEPTH_DEF : 32'(lim);
    return (out_pos + n) <= cap;
  endfunction

  function automatic void refuse_write();
    ovr_flag = 1'b1;
    mode     = MODE_HALT;
  endfunction

  function automatic void clear_block();
    mode        = MODE_HEADER;
    count_left  = '0;
    out_pos     = 0;
    hdr_left    = hdr_len;
    ovr_flag    = 1'b0;
    end_flag    = 1'b0;
    fresh_block = 1'b1;
  endfunction

  function automatic wr_word_t decode_byte(logic [BYTE_W-1:0] b, logic lst);
    wr_word_t w;
    w = '0;
    if (fresh_block) begin
      hdr_left    = hdr_len;
      mode        = MODE_HEADER;
      fresh_block = 1'b0;
    end
    if (mode == MODE_HEADER && hdr_left == 0) mode = MODE_CMD;
    case (mode)
      MODE_HEADER: begin
        if (!room_for(1)) begin
          refuse_write();
        end else begin
          w.addr  = out_pos[ADDR_W-1:0];
          w.value = b;
          w.run   = BYTE_W'(1);
          out_pos++;
          hdr_left--;
          if (hdr_left == 0) mode = MODE_CMD;
        end
      end
      MODE_CMD: begin
        if (b == CMD_END) begin
          mode     = MODE_END;
          end_flag = 1'b1;
        end else if (b == CMD_LITERAL) begin
          mode = MODE_COUNT;
        end else begin
          count_left = b;
          mode       = MODE_REPEAT;
        end
      end
      MODE_COUNT: begin
        if (b == '0) begin
          mode = MODE_CMD;
        end else if (!room_for(32'(b))) begin
          refuse_write();
        end else begin
          count_left = b;
          mode       = MODE_LITERAL;
        end
      end
      MODE_LITERAL: begin
        if (!room_for(1)) begin
          refuse_write();
        end else begin
          w.addr  = out_pos[ADDR_W-1:0];
          w.value = b;
          w.run   = BYTE_W'(1);
          out_pos++;
          count_left--;
          if (count_left == 0) mode = MODE_CMD;
        end
      end
      MODE_REPEAT: begin
        if (!room_for(32'(count_left))) begin
          refuse_write();
        end else begin
          w.addr     = out_pos[ADDR_W-1:0];
          w.value    = b;
          w.run      = count_left;
          out_pos    = out_pos + 32'(count_left);
          count_left = '0;
          mode       = MODE_CMD;
        end
      end
      default: begin
      end
    endcase
    w.end_seen = end_flag;
    w.overrun  = ovr_flag;
    if (lst) clear_block();
    return w;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errs++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    wr_word_t got;
    wr_word_t want;
    if (!rst_ni) begin
      lim     = OUT_LIMIT_RST;
      hdr_len = HEADER_LEN_RST;
      clear_block();
      words_due.delete();
      waiting = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got = {out_mon.write_addr, out_mon.write_value, out_mon.run_length,
               out_mon.end_seen, out_mon.overrun};
        if (words_due.size() == 0) begin
          $error("write word with no byte behind it: addr %0d value %0d run %0d",
                 got.addr, got.value, got.run);
          errs++;
        end else begin
          want = words_due.pop_front();
          check_field("write_addr", 32'(want.addr), 32'(got.addr));
          check_field("write_value", 32'(want.value), 32'(got.value));
          check_field("run_length", 32'(want.run), 32'(got.run));
          check_field("end_seen", 32'(want.end_seen), 32'(got.end_seen));
          check_field("overrun", 32'(want.overrun), 32'(got.overrun));
        end
      end
      if (psel && penable && pwrite && pready) begin
        if (paddr == {REG_OUT_LIMIT, 2'b00}) begin
          lim = pwdata[OUT_LIMIT_W-1:0];
        end else if (paddr == {REG_HEADER_LEN, 2'b00}) begin
          hdr_len = pwdata[HEADER_LEN_W-1:0];
          if (fresh_block) hdr_left = hdr_len;
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        words_due.push_back(decode_byte(in_mon.in_byte, in_mon.last_byte));
      end
      waiting = words_due.size();
    end
  end

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// Run-length byte decoder testbench
// Drives compressed blocks into the decoder with random gaps and output
// stalls, reprograms the output limit and header length between phases, and
// leaves all prediction and comparison to the word checker.
// ----------------------------------------------------------------------------
module tb;
  import rlbd_pkg::*;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned ITEM_TARGET = 1600;
  localparam int unsigned LONG_HOLD   = 300;

  typedef logic [BYTE_W-1:0] byte_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    psel;
  logic                    penable;
  logic                    pwrite;
  logic                    pready;
  logic [PADDR_W-1:0]      paddr;
  logic [PDATA_W-1:0]      pwdata;
  logic [PDATA_W-1:0]      prdata;
  int                      err_cnt;
  int                      words_pending;
  bit                      src_idle;
  bit                      snk_idle;
  int unsigned             bytes_sent;
  int unsigned             words_taken;
  logic [HEADER_LEN_W-1:0] cur_hdr;

  rlbd_in_if  in_ch ();
  rlbd_out_if out_ch ();

  run_length_byte_decoder_unit dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_ch),
    .out_o   (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  rlbd_word_checker chk (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_mon    (in_ch),
    .out_mon   (out_ch),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .pready    (pready),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .err_cnt_o (err_cnt),
    .pending_o (words_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic apb_write(input logic idx, input logic [PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
  endtask

  task automatic set_config(input logic [OUT_LIMIT_W-1:0] lim_v,
                            input logic [HEADER_LEN_W-1:0] hdr_v);
    apb_write(REG_OUT_LIMIT, PDATA_W'(lim_v));
    apb_write(REG_HEADER_LEN, PDATA_W'(hdr_v));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cur_hdr = hdr_v;
  endtask

  // The decoder is idle once every predicted word has been taken.
  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(negedge clk_i); while (words_pending != 0);
    @(posedge clk_i);
  endtask

  task automatic send_byte(input byte_t b, input logic lst);
    int unsigned gap;
    gap = src_idle ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.in_byte   <= b;
    in_ch.last_byte <= lst;
    do @(posedge clk_i); while (!in_ch.ready);
    bytes_sent++;
  endtask

  task automatic send_seq(input byte_t seq[$], input bit close);
    foreach (seq[i]) send_byte(seq[i], close && (i == seq.size() - 1));
  endtask

  task automatic send_block(input bit keep_open);
    byte_t       blk[$];
    int unsigned kind;
    int unsigned cnt;
    int unsigned keep;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 20)) blk.push_back(byte_t'($urandom));
    end else begin
      repeat (cur_hdr) blk.push_back(byte_t'($urandom));
      repeat ($urandom_range(1, 8)) begin
        kind = $urandom_range(0, 9);
        if (kind < 4) begin
          blk.push_back(byte_t'($urandom_range(1, 254)));
          blk.push_back(byte_t'($urandom));
        end else if (kind < 8) begin
          cnt = ($urandom_range(0, 15) == 0) ? $urandom_range(13, 255) : $urandom_range(1, 12);
          blk.push_back(CMD_LITERAL);
          blk.push_back(byte_t'(cnt));
          repeat (cnt) blk.push_back(byte_t'($urandom));
        end else if (kind == 8) begin
          blk.push_back(CMD_LITERAL);
          blk.push_back('0);
        end else begin
          blk.push_back(byte_t'($urandom));
        end
      end
      if ($urandom_range(0, 3) != 0) begin
        blk.push_back(CMD_END);
        repeat ($urandom_range(0, 3)) blk.push_back(byte_t'($urandom));
      end
      if ($urandom_range(0, 7) == 0) begin
        keep = $urandom_range(1, blk.size());
        while (blk.size() > keep) void'(blk.pop_back());
      end
    end
    send_seq(blk, !keep_open);
  endtask

  initial begin
    logic [OUT_LIMIT_W-1:0]  lim_v;
    logic [HEADER_LEN_W-1:0] hdr_v;
    rst_ni          = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    in_ch.valid     = 1'b0;
    in_ch.in_byte   = '0;
    in_ch.last_byte = 1'b0;
    src_idle        = 1'b0;
    snk_idle        = 1'b0;
    bytes_sent      = 0;
    cur_hdr         = HEADER_LEN_RST;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // A limit above the buffer size, header bytes equal to command codes,
    // shortest and longest runs, an empty and a short literal string, then
    // the end command followed by a byte that must be ignored.
    set_config('1, 4'd2);
    send_seq('{8'h00, 8'hFF, 8'h01, 8'hAB, 8'hFE, 8'h55, CMD_LITERAL, 8'h00,
               CMD_LITERAL, 8'h02, 8'h00, 8'hFF, CMD_END, 8'h37}, 1'b1);
    settle();
    set_config('0, '0);
    send_seq('{CMD_LITERAL, 8'h05, 8'h12}, 1'b1);
    settle();
    set_config(14'd3, 4'd1);
    send_seq('{8'h10, 8'h03, 8'h77, 8'h99}, 1'b1);

    while (bytes_sent < ITEM_TARGET) begin
      settle();
      case ($urandom_range(0, 6))
        0:       lim_v = '0;
        1:       lim_v = 14'd1;
        2:       lim_v = OUT_LIMIT_W'($urandom_range(2, 64));
        3:       lim_v = OUT_LIMIT_W'(OUT_DEPTH_DEF);
        4:       lim_v = '1;
        default: lim_v = OUT_LIMIT_W'($urandom_range(65, OUT_DEPTH_DEF));
      endcase
      case ($urandom_range(0, 3))
        0:       hdr_v = '0;
        1:       hdr_v = '1;
        default: hdr_v = HEADER_LEN_W'($urandom_range(0, 15));
      endcase
      set_config(lim_v, hdr_v);
      src_idle = $urandom_range(0, 3) != 0;
      snk_idle = $urandom_range(0, 3) != 0;
      repeat ($urandom_range(2, 6)) send_block(1'b0);
      send_block($urandom_range(0, 2) == 0);
    end

    in_ch.valid <= 1'b0;
    do @(negedge clk_i); while (words_pending != 0);
    repeat (4) @(posedge clk_i);
    if (err_cnt == 0 && words_pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    int unsigned stall;
    bit          held;
    out_ch.ready = 1'b0;
    held         = 1'b0;
    words_taken  = 0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      stall = snk_idle ? $urandom_range(0, 5) : 0;
      if (!held && words_taken >= 500 && in_ch.valid) begin
        stall = LONG_HOLD;
        held  = 1'b1;
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
      words_taken++;
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("DONE: errors detected");
    $finish;
  end

endmodule

@@ run_length_byte_decoder_unit.f @@
design/rlbd_pkg.sv
design/rlbd_if.sv
design/run_length_byte_decoder_unit.sv
tb/rlbd_word_checker.sv
tb/tb.sv
